// ===== rtl/ssfc_pkg.sv =====
// Shared types and constants for the servo status frame checker.
`default_nettype none

package ssfc_pkg;

    // Frame constants
    localparam logic [7:0] HDR_BYTE = 8'hFF;
    localparam logic [7:0] LEN_ACK  = 8'h02;
    localparam logic [7:0] LEN_POS  = 8'h04;
    localparam logic [7:0] ERR_NONE = 8'h00;

    // Index of the checksum byte for each reply kind
    localparam logic [2:0] LAST_ACK = 3'd5;
    localparam logic [2:0] LAST_POS = 3'd7;

    // Byte positions inside a frame
    localparam logic [2:0] IDX_ID   = 3'd2;
    localparam logic [2:0] IDX_LEN  = 3'd3;
    localparam logic [2:0] IDX_ERR  = 3'd4;
    localparam logic [2:0] IDX_POSL = 3'd5;
    localparam logic [2:0] IDX_POSH = 3'd6;

    // Reset values of the configuration registers
    localparam logic [7:0] RST_MATCH_ID   = 8'd1;
    localparam logic       RST_REPLY_KIND = 1'b0;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_MATCH_ID   = 1'b0,
        CFG_REPLY_KIND = 1'b1
    } t_cfg_idx;

    // Frame status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_HDR_BAD  = 2'd1,
        ST_CSUM_BAD = 2'd2,
        ST_DEV_ERR  = 2'd3
    } t_status;

    // Configuration as seen by the frame logic
    typedef struct packed {
        logic [7:0] match_id;
        logic       reply_kind;
    } t_cfg;

    // One result item
    typedef struct packed {
        logic [1:0]  frame_status;
        logic [7:0]  device_error;
        logic [15:0] position;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/ssfc_if.sv =====
// Channel interfaces: received bytes, frame status results, configuration writes.
`default_nettype none

interface ssfc_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       restart;

    modport source (output valid, output rx_byte, output restart, input ready);
    modport sink   (input valid, input rx_byte, input restart, output ready);
endinterface

interface ssfc_status_if;
    logic        valid;
    logic        ready;
    logic [1:0]  frame_status;
    logic [7:0]  device_error;
    logic [15:0] position;

    modport source (output valid, output frame_status, output device_error,
                    output position, input ready);
    modport sink   (input valid, input frame_status, input device_error,
                    input position, output ready);
endinterface

interface ssfc_cfg_if;
    logic       valid;
    logic       ready;
    logic [0:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/ssfc_cfg_regs.sv =====
// Configuration registers: expected id and reply kind.
`default_nettype none

module ssfc_cfg_regs (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_wr_en,
    input  wire  [0:0]       i_wr_idx,
    input  wire  [7:0]       i_wr_data,
    output ssfc_pkg::t_cfg   o_cfg
);

    ssfc_pkg::t_cfg r_cfg;
    ssfc_pkg::t_cfg n_cfg;

    // Register write decode
    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            unique case (ssfc_pkg::t_cfg_idx'(i_wr_idx))
                ssfc_pkg::CFG_MATCH_ID:   n_cfg.match_id   = i_wr_data;
                ssfc_pkg::CFG_REPLY_KIND: n_cfg.reply_kind = i_wr_data[0];
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.match_id   <= ssfc_pkg::RST_MATCH_ID;
            r_cfg.reply_kind <= ssfc_pkg::RST_REPLY_KIND;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

`ifndef SYNTH
    // A write to the id register lands on the next edge
    a_id_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr_en && (i_wr_idx == ssfc_pkg::CFG_MATCH_ID)
        |=> r_cfg.match_id == $past(i_wr_data))
        else $error("expected id not written");

    // Without a write the configuration holds
    a_cfg_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_wr_en |=> $stable(r_cfg))
        else $error("configuration changed without a write");

    // Reset brings the default id
    a_cfg_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> r_cfg.match_id == ssfc_pkg::RST_MATCH_ID)
        else $error("expected id not reset");
`endif

endmodule

`default_nettype wire

// ===== rtl/ssfc_frame_core.sv =====
// Frame state and per-byte checking: byte index, running sum, held fields, status.
`default_nettype none

module ssfc_frame_core (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_step,
    input  wire  [7:0]         i_byte,
    input  wire                i_restart,
    input  ssfc_pkg::t_cfg     i_cfg,
    output logic               o_res_valid,
    output ssfc_pkg::t_result  o_result
);

    logic [2:0] r_byte_index, n_byte_index;
    logic [7:0] r_sum,        n_sum;
    logic       r_hdr_bad,    n_hdr_bad;
    logic [7:0] r_err,        n_err;
    logic [7:0] r_pos_lo,     n_pos_lo;
    logic [7:0] r_pos_hi,     n_pos_hi;

    logic [2:0] idx;
    logic       clr;
    logic [2:0] last_idx;
    logic       is_last;
    logic [7:0] sum_b;
    logic       hdr_b;
    logic [7:0] err_b;
    logic [7:0] pl_b;
    logic [7:0] ph_b;

    // Frame position and per-frame state as seen by this byte
    always_comb begin
        idx      = i_restart ? 3'd0 : r_byte_index;
        clr      = (idx == 3'd0);
        last_idx = i_cfg.reply_kind ? ssfc_pkg::LAST_POS : ssfc_pkg::LAST_ACK;
        is_last  = (idx >= last_idx);
        sum_b    = clr ? 8'd0 : r_sum;
        hdr_b    = clr ? 1'b0 : r_hdr_bad;
        err_b    = clr ? 8'd0 : r_err;
        pl_b     = clr ? 8'd0 : r_pos_lo;
        ph_b     = clr ? 8'd0 : r_pos_hi;
    end

    // Result on the checksum byte, status in priority order
    always_comb begin
        o_res_valid = is_last;
        if (hdr_b) begin
            o_result.frame_status = ssfc_pkg::ST_HDR_BAD;
        end else if (~sum_b != i_byte) begin
            o_result.frame_status = ssfc_pkg::ST_CSUM_BAD;
        end else if (err_b != ssfc_pkg::ERR_NONE) begin
            o_result.frame_status = ssfc_pkg::ST_DEV_ERR;
        end else begin
            o_result.frame_status = ssfc_pkg::ST_OK;
        end
        o_result.device_error = err_b;
        o_result.position     = i_cfg.reply_kind ? {ph_b, pl_b} : 16'd0;
    end

    // Next state for this byte
    always_comb begin
        n_byte_index = idx + 3'd1;
        n_sum        = sum_b;
        n_hdr_bad    = hdr_b;
        n_err        = err_b;
        n_pos_lo     = pl_b;
        n_pos_hi     = ph_b;
        if (is_last) begin
            n_byte_index = 3'd0;
        end else if (idx <= 3'd1) begin
            if (i_byte != ssfc_pkg::HDR_BYTE) n_hdr_bad = 1'b1;
        end else begin
            n_sum = sum_b + i_byte;
            case (idx)
                ssfc_pkg::IDX_ID: begin
                    if (i_byte != i_cfg.match_id) n_hdr_bad = 1'b1;
                end
                ssfc_pkg::IDX_LEN: begin
                    if (i_byte != (i_cfg.reply_kind ? ssfc_pkg::LEN_POS
                                                    : ssfc_pkg::LEN_ACK))
                        n_hdr_bad = 1'b1;
                end
                ssfc_pkg::IDX_ERR:  n_err    = i_byte;
                ssfc_pkg::IDX_POSL: n_pos_lo = i_byte;
                ssfc_pkg::IDX_POSH: n_pos_hi = i_byte;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_index <= 3'd0;
            r_sum        <= 8'd0;
            r_hdr_bad    <= 1'b0;
            r_err        <= 8'd0;
            r_pos_lo     <= 8'd0;
            r_pos_hi     <= 8'd0;
        end else if (i_step) begin
            r_byte_index <= n_byte_index;
            r_sum        <= n_sum;
            r_hdr_bad    <= n_hdr_bad;
            r_err        <= n_err;
            r_pos_lo     <= n_pos_lo;
            r_pos_hi     <= n_pos_hi;
        end
    end

`ifndef SYNTH
    // A frame ends with the index back at zero
    a_end_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_res_valid |=> r_byte_index == 3'd0)
        else $error("byte index not cleared after checksum byte");

    // An ok frame never carries a device error
    a_ok_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && (o_result.frame_status == ssfc_pkg::ST_OK)
        |-> o_result.device_error == ssfc_pkg::ERR_NONE)
        else $error("ok status with nonzero device error");

    // A restart byte never ends a frame
    a_restart_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_restart |=> r_byte_index == 3'd1)
        else $error("restart byte not taken as byte 0");
`endif

endmodule

`default_nettype wire

// ===== rtl/servo_status_frame_checker.sv =====
// Top level: input byte register, frame checker, status result register.
`default_nettype none

// Checks servo reply frames one received byte at a time and gives one status
// item on each checksum byte. The block takes one byte per clock cycle while
// the status result is not stalled: a byte is held in an input register, goes
// through the frame checker's combinational logic and lands in the result
// register, so a status item is valid once its checksum byte has passed the
// input register and the result register. A stalled result holds the input
// register, which still lets one more byte in. Configuration writes are taken
// in every cycle.
module servo_status_frame_checker (
    input  wire             i_clk,
    input  wire             i_rst_n,
    ssfc_rx_if.sink         i_rx,
    ssfc_status_if.source   o_status,
    ssfc_cfg_if.sink        i_cfg
);

    ssfc_pkg::t_cfg    cfg;
    ssfc_pkg::t_result res;
    logic              res_valid;
    logic              out_free;
    logic              step;
    logic              in_take;

    logic              r_in_valid, n_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_in_restart;
    logic              r_out_valid, n_out_valid;
    ssfc_pkg::t_result r_out;

    assign i_cfg.ready = 1'b1;

    ssfc_cfg_regs u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (i_cfg.valid),
        .i_wr_idx  (i_cfg.index),
        .i_wr_data (i_cfg.data),
        .o_cfg     (cfg)
    );

    // Handshake: the held byte advances when the result register can take it
    assign out_free   = !r_out_valid || o_status.ready;
    assign step       = r_in_valid && out_free;
    assign i_rx.ready = !r_in_valid || out_free;
    assign in_take    = i_rx.valid && i_rx.ready;

    always_comb begin
        n_in_valid  = in_take ? 1'b1 : (step ? 1'b0 : r_in_valid);
        n_out_valid = out_free ? (step && res_valid) : r_out_valid;
    end

    ssfc_frame_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_byte      (r_in_byte),
        .i_restart   (r_in_restart),
        .i_cfg       (cfg),
        .o_res_valid (res_valid),
        .o_result    (res)
    );

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte    <= i_rx.rx_byte;
            r_in_restart <= i_rx.restart;
        end
        if (step && res_valid) begin
            r_out <= res;
        end
    end

    assign o_status.valid        = r_out_valid;
    assign o_status.frame_status = r_out.frame_status;
    assign o_status.device_error = r_out.device_error;
    assign o_status.position     = r_out.position;

`ifndef SYNTH
    // A stalled result keeps the held byte waiting
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_status.ready && r_in_valid |=> r_in_valid)
        else $error("held byte dropped while result stalled");

    // A new result only comes from a processed byte
    a_res_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid && !step |=> !r_out_valid)
        else $error("result appeared without a byte");

    // Nothing is pending right after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_out_valid && !r_in_valid)
        else $error("registers not empty after reset");
`endif

endmodule

`default_nettype wire
